>>> hdl/jbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbl_pkg
// shared types and codes of the json byte stream lexer
// ----------------------------------------------------------------------------
package jbl_pkg;

	localparam int MaxRes = 4;

	localparam logic [1:0] EV_VALUE = 2'd0;
	localparam logic [1:0] EV_TOKEN = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;
	localparam logic [1:0] EV_EOF   = 2'd3;

	localparam logic [3:0] TT_LBRACE = 4'd0;
	localparam logic [3:0] TT_RBRACE = 4'd1;
	localparam logic [3:0] TT_LBRACK = 4'd2;
	localparam logic [3:0] TT_RBRACK = 4'd3;
	localparam logic [3:0] TT_COLON  = 4'd4;
	localparam logic [3:0] TT_COMMA  = 4'd5;
	localparam logic [3:0] TT_STRING = 4'd6;
	localparam logic [3:0] TT_NUMBER = 4'd7;
	localparam logic [3:0] TT_EOF    = 4'd11;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_UNEXPECT  = 4'd1;
	localparam logic [3:0] ERR_END_ESC   = 4'd2;
	localparam logic [3:0] ERR_END_HEX   = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX   = 4'd4;
	localparam logic [3:0] ERR_BAD_ESC   = 4'd5;
	localparam logic [3:0] ERR_CTRL      = 4'd6;
	localparam logic [3:0] ERR_UNTERM    = 4'd7;
	localparam logic [3:0] ERR_BAD_NUM   = 4'd8;
	localparam logic [3:0] ERR_LEAD_ZERO = 4'd9;
	localparam logic [3:0] ERR_BAD_EXP   = 4'd10;
	localparam logic [3:0] ERR_LITERAL   = 4'd11;

	typedef struct packed {
		logic [1:0]  ev;
		logic [3:0]  tt;
		logic [7:0]  vb;
		logic [3:0]  ec;
		logic [23:0] ln;
		logic [15:0] col;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] r;
		logic [2:0]        cnt;
	} group_t;

endpackage
`default_nettype wire

>>> hdl/jbl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbl_front
// lexer state machine: classifies one byte per cycle, while take is high, into a result group
// ----------------------------------------------------------------------------
module jbl_front import jbl_pkg::*; #(
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         take,
	input  wire [7:0]   text_byte,
	input  wire         byte_valid,
	input  wire         end_of_text,
	output group_t      grp,
	output logic        grp_valid
);

	localparam logic [4:0] M_IDLE  = 5'd0;
	localparam logic [4:0] M_STR   = 5'd1;
	localparam logic [4:0] M_ESC   = 5'd2;
	localparam logic [4:0] M_HEX   = 5'd3;
	localparam logic [4:0] M_MINUS = 5'd4;
	localparam logic [4:0] M_ZERO  = 5'd5;
	localparam logic [4:0] M_INT   = 5'd6;
	localparam logic [4:0] M_DOT   = 5'd7;
	localparam logic [4:0] M_FRAC  = 5'd8;
	localparam logic [4:0] M_E     = 5'd9;
	localparam logic [4:0] M_ESIGN = 5'd10;
	localparam logic [4:0] M_EXP   = 5'd11;
	localparam logic [4:0] M_LIT   = 5'd12;
	localparam logic [4:0] M_DONE  = 5'd13;

	logic [4:0]             mode_q, m;
	logic [15:0]            acc_q, acc, nacc;
	logic [1:0]             hc_q, hc;
	logic [5:0]             lp_q, lp;
	logic [LINE_BITS-1:0]   line_q, nline;
	logic [COLUMN_BITS-1:0] col_q, ncol;
	logic [23:0]            tsl_q, tsl, pl, npl;
	logic [15:0]            tsc_q, tsc, pc, npc;
	logic                   halt_q, halt;
	logic [31:0]            lw, cw, nlw, ncw;
	res_t [MaxRes-1:0]      r;
	logic [2:0]             n;
	logic                   do_idle, close;
	logic [4:0]             hx;
	logic [7:0]             b, esc_cp;
	logic                   esc_ok;

	function automatic res_t mk(logic [1:0] ev, logic [3:0] tt, logic [7:0] vb,
			logic [3:0] ec, logic [23:0] ln, logic [15:0] col);
		res_t x;
		x.ev = ev; x.tt = tt; x.vb = vb; x.ec = ec; x.ln = ln; x.col = col;
		return x;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_of(logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (is_digit(c)) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] lit_char(logic [1:0] cand, logic [3:0] cnt);
		logic [7:0] c;
		c = 8'h00;
		unique case ({cand, cnt})
			{2'd1, 4'd0}: c = "t";
			{2'd1, 4'd1}: c = "r";
			{2'd1, 4'd2}: c = "u";
			{2'd1, 4'd3}: c = "e";
			{2'd2, 4'd0}: c = "f";
			{2'd2, 4'd1}: c = "a";
			{2'd2, 4'd2}: c = "l";
			{2'd2, 4'd3}: c = "s";
			{2'd2, 4'd4}: c = "e";
			{2'd3, 4'd0}: c = "n";
			{2'd3, 4'd1}: c = "u";
			{2'd3, 4'd2}: c = "l";
			{2'd3, 4'd3}: c = "l";
			default:      c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] lit_len(logic [1:0] cand);
		unique case (cand)
			2'd1:    return 4'd4;
			2'd2:    return 4'd5;
			2'd3:    return 4'd4;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic lit_ok(logic [5:0] p);
		return p[5:4] != 2'd0 && p[3:0] == lit_len(p[5:4]);
	endfunction

	always_comb begin
		b = text_byte;
		lw = 32'(line_q);
		cw = 32'(col_q);
		pl = lw[23:0];
		pc = cw[15:0];
		nline = line_q;
		ncol = col_q;
		if (byte_valid) begin
			if (b == 8'h0A) begin
				if (line_q != {LINE_BITS{1'b1}}) nline = line_q + 1'b1;
				ncol = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
			end else if (col_q != {COLUMN_BITS{1'b1}}) begin
				ncol = col_q + 1'b1;
			end
		end
		nlw = 32'(nline);
		ncw = 32'(ncol);
		npl = nlw[23:0];
		npc = ncw[15:0];

		m = mode_q; acc = acc_q; hc = hc_q; lp = lp_q;
		tsl = tsl_q; tsc = tsc_q; halt = halt_q;
		r = '0; n = 3'd0; do_idle = 1'b0; close = 1'b0;
		hx = hex_of(b);
		nacc = {acc_q[11:0], hx[3:0]};
		esc_ok = 1'b1;
		unique case (b)
			8'h22, 8'h5C, 8'h2F: esc_cp = b;
			"b":     esc_cp = 8'h08;
			"f":     esc_cp = 8'h0C;
			"n":     esc_cp = 8'h0A;
			"r":     esc_cp = 8'h0D;
			"t":     esc_cp = 8'h09;
			default: begin esc_cp = 8'h00; esc_ok = 1'b0; end
		endcase

		if (!halt_q && mode_q != M_DONE && byte_valid) begin
			unique case (mode_q)
				M_IDLE: do_idle = 1'b1;
				M_STR: begin
					if (b == 8'h22) begin
						r[n[1:0]] = mk(EV_TOKEN, TT_STRING, 8'h00, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_IDLE;
					end else if (b == 8'h5C) begin
						m = M_ESC;
					end else if (b < 8'h20) begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_CTRL, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end else begin
						r[n[1:0]] = mk(EV_VALUE, TT_STRING, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1;
					end
				end
				M_ESC: begin
					if (b == "u") begin
						acc = 16'h0; hc = 2'd0; m = M_HEX;
					end else if (esc_ok) begin
						r[n[1:0]] = mk(EV_VALUE, TT_STRING, esc_cp, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_STR;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_ESC, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				M_HEX: begin
					if (!hx[4]) begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_HEX, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end else if (hc_q != 2'd3) begin
						acc = nacc; hc = hc_q + 2'd1;
					end else begin
						// utf-8 expansion of the code point
						if (nacc <= 16'h007F) begin
							r[0] = mk(EV_VALUE, TT_STRING, nacc[7:0], ERR_NONE, tsl, tsc);
							n = 3'd1;
						end else if (nacc <= 16'h07FF) begin
							r[0] = mk(EV_VALUE, TT_STRING, {3'b110, nacc[10:6]}, ERR_NONE,
								tsl, tsc);
							r[1] = mk(EV_VALUE, TT_STRING, {2'b10, nacc[5:0]}, ERR_NONE,
								tsl, tsc);
							n = 3'd2;
						end else begin
							r[0] = mk(EV_VALUE, TT_STRING, {4'b1110, nacc[15:12]}, ERR_NONE,
								tsl, tsc);
							r[1] = mk(EV_VALUE, TT_STRING, {2'b10, nacc[11:6]}, ERR_NONE,
								tsl, tsc);
							r[2] = mk(EV_VALUE, TT_STRING, {2'b10, nacc[5:0]}, ERR_NONE,
								tsl, tsc);
							n = 3'd3;
						end
						acc = 16'h0; hc = 2'd0; m = M_STR;
					end
				end
				M_MINUS: begin
					if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = (b == 8'h30) ? M_ZERO : M_INT;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_NUM, tsl, tsc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				M_ZERO, M_INT: begin
					if (is_digit(b)) begin
						if (mode_q == M_ZERO) begin
							r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_LEAD_ZERO, pl, pc);
							n = n + 3'd1; halt = 1'b1;
						end else begin
							r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
							n = n + 3'd1;
						end
					end else if (b == 8'h2E) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_DOT;
					end else if (b == "e" || b == "E") begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_E;
					end else begin
						close = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_FRAC;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_NUM, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1;
					end else if (b == "e" || b == "E") begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_E;
					end else begin
						close = 1'b1;
					end
				end
				M_E: begin
					if (b == 8'h2B || b == 8'h2D) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_ESIGN;
					end else if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_EXP;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_EXP, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				M_ESIGN: begin
					if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1; m = M_EXP;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_EXP, pl, pc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				M_EXP: begin
					if (is_digit(b)) begin
						r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, tsl, tsc);
						n = n + 3'd1;
					end else begin
						close = 1'b1;
					end
				end
				M_LIT: begin
					if (is_alpha(b)) begin
						if (lp_q[5:4] != 2'd0 && lp_q[3:0] < lit_len(lp_q[5:4])
								&& lit_char(lp_q[5:4], lp_q[3:0]) == b)
							lp = {lp_q[5:4], lp_q[3:0] + 4'd1};
						else
							lp = 6'd0;
					end else if (lit_ok(lp_q)) begin
						r[n[1:0]] = mk(EV_TOKEN, TT_NUMBER + {2'b00, lp_q[5:4]}, 8'h00,
							ERR_NONE, tsl, tsc);
						n = n + 3'd1; lp = 6'd0; m = M_IDLE; do_idle = 1'b1;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_LITERAL, tsl, tsc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				default: ;
			endcase

			// a byte after a number closes it, then starts the next token; a letter, '.', '+' or '-' is an error
			if (close) begin
				if (is_alpha(b) || b == 8'h2E || b == 8'h2B || b == 8'h2D) begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_NUM, pl, pc);
					n = n + 3'd1; halt = 1'b1;
				end else begin
					r[n[1:0]] = mk(EV_TOKEN, TT_NUMBER, 8'h00, ERR_NONE, tsl, tsc);
					n = n + 3'd1; m = M_IDLE; do_idle = 1'b1;
				end
			end

			if (do_idle) begin
				priority if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
				end else if (b == 8'h7B) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_LBRACE, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h7D) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_RBRACE, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h5B) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_LBRACK, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h5D) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_RBRACK, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h3A) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_COLON, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h2C) begin
					r[n[1:0]] = mk(EV_TOKEN, TT_COMMA, 8'h00, ERR_NONE, pl, pc);
					n = n + 3'd1;
				end else if (b == 8'h22) begin
					tsl = pl; tsc = pc; m = M_STR;
				end else if (is_digit(b) || b == 8'h2D) begin
					tsl = pl; tsc = pc;
					r[n[1:0]] = mk(EV_VALUE, TT_NUMBER, b, ERR_NONE, pl, pc);
					n = n + 3'd1;
					m = (b == 8'h2D) ? M_MINUS : ((b == 8'h30) ? M_ZERO : M_INT);
				end else if (is_alpha(b)) begin
					tsl = pl; tsc = pc; m = M_LIT;
					priority if (b == "t") lp = 6'h11;
					else if (b == "f") lp = 6'h21;
					else if (b == "n") lp = 6'h31;
					else lp = 6'h00;
				end else begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_UNEXPECT, pl, pc);
					n = n + 3'd1; halt = 1'b1;
				end
			end
		end

		if (!halt_q && mode_q != M_DONE && end_of_text && !halt) begin
			unique case (m)
				M_STR: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_UNTERM, tsl, tsc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_ESC: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_END_ESC, npl, npc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_HEX: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_END_HEX, npl, npc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_MINUS: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_NUM, tsl, tsc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_DOT: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_NUM, npl, npc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_E, M_ESIGN: begin
					r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_BAD_EXP, npl, npc);
					n = n + 3'd1; halt = 1'b1;
				end
				M_ZERO, M_INT, M_FRAC, M_EXP: begin
					r[n[1:0]] = mk(EV_TOKEN, TT_NUMBER, 8'h00, ERR_NONE, tsl, tsc);
					n = n + 3'd1;
				end
				M_LIT: begin
					if (lit_ok(lp)) begin
						r[n[1:0]] = mk(EV_TOKEN, TT_NUMBER + {2'b00, lp[5:4]}, 8'h00,
							ERR_NONE, tsl, tsc);
						n = n + 3'd1; lp = 6'd0;
					end else begin
						r[n[1:0]] = mk(EV_ERROR, 4'd0, 8'h00, ERR_LITERAL, tsl, tsc);
						n = n + 3'd1; halt = 1'b1;
					end
				end
				default: ;
			endcase
			if (!halt) begin
				r[n[1:0]] = mk(EV_EOF, TT_EOF, 8'h00, ERR_NONE, npl, npc);
				n = n + 3'd1; m = M_DONE;
			end
		end

		grp.r = r;
		grp.cnt = n;
		grp_valid = take && n != 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= 16'h0;
			hc_q   <= 2'd0;
			lp_q   <= 6'd0;
			line_q <= {{(LINE_BITS-1){1'b0}}, 1'b1};
			col_q  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
			tsl_q  <= 24'd1;
			tsc_q  <= 16'd1;
			halt_q <= 1'b0;
		end else if (take && !halt_q && mode_q != M_DONE) begin
			mode_q <= m;
			acc_q  <= acc;
			hc_q   <= hc;
			lp_q   <= lp;
			line_q <= nline;
			col_q  <= ncol;
			tsl_q  <= tsl;
			tsc_q  <= tsc;
			halt_q <= halt;
		end
	end

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q && $stable(mode_q))
		else $error("halt released");
	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid |-> grp.cnt <= 3'(MaxRes))
		else $error("group overflow");
	a_quiet_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(halt_q || mode_q == M_DONE) |-> !grp_valid)
		else $error("result after stop");

endmodule
`default_nettype wire

>>> hdl/jbl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbl_back
// group queue and serializer: delivers one result per pop
// ----------------------------------------------------------------------------
module jbl_back import jbl_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         wr,
	input  group_t      grp,
	output logic        full,
	output logic        empty,
	input  wire         pop,
	output res_t        res,
	output logic        last
);

	localparam int Depth = 4;

	group_t     mem_q [Depth];
	logic [1:0] wp_q, rp_q, sub_q;
	logic [2:0] cnt_q;
	logic       adv, rd;
	group_t     head;

	assign head  = mem_q[rp_q];
	assign full  = cnt_q == 3'(Depth);
	assign empty = cnt_q == 3'd0;
	assign res   = head.r[sub_q];
	assign last  = {1'b0, sub_q} == head.cnt - 3'd1;
	assign rd    = pop && !empty;
	assign adv   = rd && last;

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			sub_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 2'd1;
			if (adv) begin
				rp_q  <= rp_q + 2'd1;
				sub_q <= 2'd0;
			end else if (rd) begin
				sub_q <= sub_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, wr && !full} - {2'b00, adv};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(Depth))
		else $error("queue count overflow");
	a_sub_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head.cnt != 3'd0 && {1'b0, sub_q} < head.cnt))
		else $error("sub index out of group");
	a_write_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !full) |=> !empty)
		else $error("written group lost");

endmodule
`default_nettype wire

>>> hdl/json_byte_stream_lexer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_stream_lexer_top
// json byte stream lexer with line and column tracking
// ----------------------------------------------------------------------------
// usage:
//   input queue side: drive text_byte, byte_valid, end_of_text with push; a
//   transaction happens when push is high and full is low. one byte per cycle.
//   result queue side: while empty is low the oldest result sits on the
//   result ports; pop takes it. last_of_run marks the final result of a byte.
//   a byte's results are registered in the group queue when the byte is taken.
//   throughput: one byte per cycle while full is low; the single-read serializer
//   after the four-entry group queue gives one result per pop, so a byte with
//   k results holds the result side for k pops.
//   when the receiver stalls, the group queue fills and full rises; bytes
//   with no result are still taken while the queue has room.
//   reset clears the lexer to idle at line 1, column 1 and empties the queue.
//   after an error or end of file, bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module json_byte_stream_lexer_top import jbl_pkg::*; #(
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire [7:0]   text_byte,
	input  wire         byte_valid,
	input  wire         end_of_text,
	output logic        empty,
	input  wire         pop,
	output logic [1:0]  event_res,
	output logic [3:0]  token_type,
	output logic [7:0]  value_byte,
	output logic [3:0]  error_code,
	output logic [23:0] position_line,
	output logic [15:0] position_column,
	output logic        last_of_run
);

	group_t grp;
	logic   grp_valid;
	res_t   res;

	jbl_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(push && !full),
		.text_byte(text_byte), .byte_valid(byte_valid), .end_of_text(end_of_text),
		.grp(grp), .grp_valid(grp_valid)
	);

	jbl_back u_back (
		.clk(clk), .arst_n(arst_n), .wr(grp_valid), .grp(grp), .full(full),
		.empty(empty), .pop(pop), .res(res), .last(last_of_run)
	);

	assign event_res       = res.ev;
	assign token_type      = res.tt;
	assign value_byte      = res.vb;
	assign error_code      = res.ec;
	assign position_line   = res.ln;
	assign position_column = res.col;

endmodule
`default_nettype wire
